// ----- rtl/ccf_pkg.sv -----
package ccf_pkg;

  // Operand word width and the number of restoring divide steps.
  localparam int WORD      = 64;
  localparam int DIV_STEPS = 64;

  // Operation codes; codes with the top bit set are not supported.
  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_SUB = 4'd1;
  localparam logic [3:0] ACT_MUL = 4'd2;
  localparam logic [3:0] ACT_DIV = 4'd3;
  localparam logic [3:0] ACT_REM = 4'd4;
  localparam logic [3:0] ACT_AND = 4'd5;
  localparam logic [3:0] ACT_OR  = 4'd6;
  localparam logic [3:0] ACT_XOR = 4'd7;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_UNSUP    = 3'd4;

  localparam logic [WORD-1:0] VAL_MIN     = {1'b1, {(WORD-1){1'b0}}};
  localparam logic [WORD-1:0] VAL_MAX     = {1'b0, {(WORD-1){1'b1}}};
  localparam logic [WORD-1:0] VAL_NEG_ONE = {WORD{1'b1}};

  // Which value the final stage takes.
  typedef enum logic [1:0] {
    PICK_PRE = 2'd0,
    PICK_QUO = 2'd1,
    PICK_REM = 2'd2
  } pick_t;

  typedef struct packed {
    logic [3:0]             action;
    logic                   left_known;
    logic signed [WORD-1:0] left_value;
    logic                   right_known;
    logic signed [WORD-1:0] right_value;
  } req_t;

  typedef struct packed {
    logic                   result_known;
    logic signed [WORD-1:0] result_value;
    logic [2:0]             status;
  } rsp_t;

  // Result information that travels alongside the divider.
  typedef struct packed {
    logic [2:0]      status;
    logic [WORD-1:0] pre;
    logic            negate;
    pick_t           pick;
  } side_t;

endpackage

// ----- rtl/ccf_front.sv -----
module ccf_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid,
  input  ccf_pkg::req_t              req,
  output logic                       out_valid,
  output ccf_pkg::side_t             side,
  output logic [ccf_pkg::WORD-1:0]   dvd,
  output logic [ccf_pkg::WORD-1:0]   dsr
);

  localparam int W = ccf_pkg::WORD;
  localparam int H = W / 2;

  logic [W-1:0] a, b, sum, diff, ua_c, ub_c, pre_c;
  logic         known, ovf_add, ovf_sub;
  logic [2:0]   status_c;

  // Stage 1 registers.
  logic           s1_valid, s1_mul, s1_mneg;
  ccf_pkg::side_t s1_side;
  logic [W-1:0]   s1_ua, s1_ub;
  // Stage 2 registers.
  logic           s2_valid, s2_mul, s2_mneg;
  ccf_pkg::side_t s2_side;
  logic [W-1:0]   s2_ua, s2_ub, pp_ll, pp_lh, pp_hl, pp_hh;
  // Stage 3 registers.
  logic           s3_valid;
  ccf_pkg::side_t s3_side;
  logic [W-1:0]   s3_ua, s3_ub;

  logic [W-1:0]   mid, lo, hi;
  logic           mul_ovf;
  ccf_pkg::side_t side3_next;

  // Decode, add and subtract, logic operations and operand magnitudes.
  always_comb begin
    a       = req.left_value;
    b       = req.right_value;
    sum     = a + b;
    diff    = a - b;
    ovf_add = ((a ^ sum) & (b ^ sum)) >> (W - 1) != '0;
    ovf_sub = ((a ^ b) & (a ^ diff)) >> (W - 1) != '0;
    ua_c    = a[W-1] ? (~a + 1'b1) : a;
    ub_c    = b[W-1] ? (~b + 1'b1) : b;
    known   = req.left_known && req.right_known;
    case (req.action)
      ccf_pkg::ACT_ADD: pre_c = sum;
      ccf_pkg::ACT_SUB: pre_c = diff;
      ccf_pkg::ACT_AND: pre_c = a & b;
      ccf_pkg::ACT_OR:  pre_c = a | b;
      ccf_pkg::ACT_XOR: pre_c = a ^ b;
      default:          pre_c = '0;
    endcase
    if (!known) begin
      status_c = ccf_pkg::ST_UNKNOWN;
    end else if (req.action[3]) begin
      status_c = ccf_pkg::ST_UNSUP;
    end else if ((req.action == ccf_pkg::ACT_ADD && ovf_add) ||
                 (req.action == ccf_pkg::ACT_SUB && ovf_sub) ||
                 (req.action == ccf_pkg::ACT_DIV && a == ccf_pkg::VAL_MIN &&
                  b == ccf_pkg::VAL_NEG_ONE)) begin
      status_c = ccf_pkg::ST_OVERFLOW;
    end else if ((req.action == ccf_pkg::ACT_DIV || req.action == ccf_pkg::ACT_REM) &&
                 b == '0) begin
      status_c = ccf_pkg::ST_DIV_ZERO;
    end else begin
      status_c = ccf_pkg::ST_OK;
    end
  end

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage 1: decoded item.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.status <= status_c;
      s1_side.pre    <= pre_c;
      s1_ua          <= ua_c;
      s1_ub          <= ub_c;
      s1_mul         <= (req.action == ccf_pkg::ACT_MUL);
      s1_mneg        <= (a[W-1] ^ b[W-1]) && a != '0 && b != '0;
      case (req.action)
        ccf_pkg::ACT_DIV: begin
          s1_side.pick   <= ccf_pkg::PICK_QUO;
          s1_side.negate <= a[W-1] ^ b[W-1];
        end
        ccf_pkg::ACT_REM: begin
          s1_side.pick   <= ccf_pkg::PICK_REM;
          s1_side.negate <= a[W-1];
        end
        ccf_pkg::ACT_MUL: begin
          s1_side.pick   <= ccf_pkg::PICK_PRE;
          s1_side.negate <= (a[W-1] ^ b[W-1]) && a != '0 && b != '0;
        end
        default: begin
          s1_side.pick   <= ccf_pkg::PICK_PRE;
          s1_side.negate <= 1'b0;
        end
      endcase
    end
  end

  // Stage 2: four half-width partial products of the magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_side <= s1_side;
      s2_ua   <= s1_ua;
      s2_ub   <= s1_ub;
      s2_mul  <= s1_mul;
      s2_mneg <= s1_mneg;
      pp_ll   <= {{H{1'b0}}, s1_ua[H-1:0]} * {{H{1'b0}}, s1_ub[H-1:0]};
      pp_lh   <= {{H{1'b0}}, s1_ua[H-1:0]} * {{H{1'b0}}, s1_ub[W-1:H]};
      pp_hl   <= {{H{1'b0}}, s1_ua[W-1:H]} * {{H{1'b0}}, s1_ub[H-1:0]};
      pp_hh   <= {{H{1'b0}}, s1_ua[W-1:H]} * {{H{1'b0}}, s1_ub[W-1:H]};
    end
  end

  // Stage 3: combine the partial products and check the product range.
  always_comb begin
    mid = (pp_ll >> H) + {{H{1'b0}}, pp_lh[H-1:0]} + {{H{1'b0}}, pp_hl[H-1:0]};
    lo  = {mid[H-1:0], pp_ll[H-1:0]};
    hi  = pp_hh + (pp_lh >> H) + (pp_hl >> H) + (mid >> H);
    mul_ovf = hi != '0 || lo > (s2_mneg ? ccf_pkg::VAL_MIN : ccf_pkg::VAL_MAX);
    side3_next = s2_side;
    if (s2_mul) begin
      side3_next.pre = lo;
      if (s2_side.status == ccf_pkg::ST_OK && mul_ovf) begin
        side3_next.status = ccf_pkg::ST_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side <= side3_next;
      s3_ua   <= s2_ua;
      s3_ub   <= s2_ub;
    end
  end

  assign out_valid = s3_valid;
  assign side      = s3_side;
  assign dvd       = s3_ua;
  assign dsr       = s3_ub;

endmodule

// ----- rtl/ccf_div.sv -----
module ccf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid,
  input  ccf_pkg::side_t             side,
  input  logic [ccf_pkg::WORD-1:0]   dvd,
  input  logic [ccf_pkg::WORD-1:0]   dsr,
  output logic                       out_valid,
  output ccf_pkg::side_t             out_side,
  output logic [ccf_pkg::WORD-1:0]   quo,
  output logic [ccf_pkg::WORD-1:0]   rem
);

  localparam int W = ccf_pkg::WORD;
  localparam int N = ccf_pkg::DIV_STEPS;

  logic                 v   [N];
  logic [W-1:0]         rr  [N];
  logic [W-1:0]         dd  [N];
  logic [W-1:0]         bb  [N];
  ccf_pkg::side_t       sd  [N];

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [2*W-1:0] div_step(input logic [W-1:0] r,
                                              input logic [W-1:0] d,
                                              input logic [W-1:0] b);
    logic [W:0] t;
    logic [W:0] t_sub;
    t     = {r, d[W-1]};
    t_sub = t - {1'b0, b};
    if (t >= {1'b0, b}) begin
      return {t_sub[W-1:0], d[W-2:0], 1'b1};
    end else begin
      return {t[W-1:0], d[W-2:0], 1'b0};
    end
  endfunction

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        v[k] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= valid;
      for (int k = 1; k < N; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  // One quotient bit is settled in each stage.
  always_ff @(posedge clk) begin
    if (en) begin
      {rr[0], dd[0]} <= div_step('0, dvd, dsr);
      bb[0]          <= dsr;
      sd[0]          <= side;
      for (int k = 1; k < N; k++) begin
        {rr[k], dd[k]} <= div_step(rr[k-1], dd[k-1], bb[k-1]);
        bb[k]          <= bb[k-1];
        sd[k]          <= sd[k-1];
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_side  = sd[N-1];
  assign quo       = dd[N-1];
  assign rem       = rr[N-1];

endmodule

// ----- rtl/checked_constant_fold_alu.sv -----
// Path: three front stages, 64 divide stages and one output register lie between
// the input transfer and the result being offered.
// Throughput: one item per cycle, but the whole pipeline holds while a result
// waits to be taken; the 64-stage restoring divider sets the depth.
// Reset clears the valid bits only; no other state is kept between items.
module checked_constant_fold_alu (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ccf_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ccf_pkg::rsp_t   rsp
);

  localparam int W = ccf_pkg::WORD;

  logic                 en;
  logic                 f_valid, d_valid;
  ccf_pkg::side_t       f_side, d_side;
  logic [W-1:0]         f_dvd, f_dsr, d_quo, d_rem;
  logic [W-1:0]         mag, val;
  ccf_pkg::rsp_t        rsp_next;

  // The pipeline advances whenever the output register is free or draining.
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  ccf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (req_valid),
    .req       (req),
    .out_valid (f_valid),
    .side      (f_side),
    .dvd       (f_dvd),
    .dsr       (f_dsr)
  );

  ccf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (f_valid),
    .side      (f_side),
    .dvd       (f_dvd),
    .dsr       (f_dsr),
    .out_valid (d_valid),
    .out_side  (d_side),
    .quo       (d_quo),
    .rem       (d_rem)
  );

  // Final selection, sign correction and clearing of unknown results.
  always_comb begin
    case (d_side.pick)
      ccf_pkg::PICK_QUO: mag = d_quo;
      ccf_pkg::PICK_REM: mag = d_rem;
      default:           mag = d_side.pre;
    endcase
    val = d_side.negate ? (~mag + 1'b1) : mag;
    rsp_next.status       = d_side.status;
    rsp_next.result_known = (d_side.status == ccf_pkg::ST_OK);
    rsp_next.result_value = (d_side.status == ccf_pkg::ST_OK) ? val : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

  // A known result always reports status ok.
  a_known_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.result_known == (rsp.status == ccf_pkg::ST_OK)))
    else $error("result_known disagrees with status");

  // An unknown result carries a zero value.
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.result_known) |-> (rsp.result_value == '0))
    else $error("unknown result with non-zero value");

  // Status stays within the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status <= ccf_pkg::ST_UNSUP))
    else $error("status code out of range");

  // A stalled pipeline accepts nothing.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !req_ready)
    else $error("input taken while the output is stalled");

endmodule
